@@ sv/kdb_pkg.sv @@
// shared constants, command and status types, knight step tables
// used by every module of knight_distance_bfs; depends on nothing
package kdb_pkg;

	localparam int MAX_DIM_DEF = 128;
	localparam int CRD_W       = 7;
	localparam int CFG_W       = 8;
	localparam int IDX_W       = 8;
	localparam int MOV_W       = 8;
	localparam int STEP_COUNT  = 8;
	localparam logic [CFG_W-1:0] DIM_RST  = 8'd8;
	localparam logic [IDX_W-1:0] REG_ROWS = 8'd0;
	localparam logic [IDX_W-1:0] REG_COLS = 8'd1;

	typedef struct packed {
		logic load;
		logic clr;
		logic init;
		logic pop;
		logic nb;
	} kdb_cmd_t;

	typedef struct packed {
		logic bad;
		logic same;
		logic clr_last;
		logic q_empty;
		logic nb_last;
		logic found;
	} kdb_sts_t;

	function automatic logic signed [2:0] step_dr(input logic [2:0] k);
		logic signed [2:0] v;
		case (k)
			3'd0: v = 3'sd1;
			3'd1: v = 3'sd2;
			3'd2: v = 3'sd1;
			3'd3: v = 3'sd2;
			3'd4: v = -3'sd1;
			3'd5: v = -3'sd2;
			3'd6: v = -3'sd1;
			default: v = -3'sd2;
		endcase
		return v;
	endfunction

	function automatic logic signed [2:0] step_dc(input logic [2:0] k);
		logic signed [2:0] v;
		case (k)
			3'd0: v = 3'sd2;
			3'd1: v = 3'sd1;
			3'd2: v = -3'sd2;
			3'd3: v = -3'sd1;
			3'd4: v = 3'sd2;
			3'd5: v = 3'sd1;
			3'd6: v = -3'sd2;
			default: v = -3'sd1;
		endcase
		return v;
	endfunction

endpackage

@@ sv/kdb_datapath.sv @@
// datapath: board registers, visited memory, frontier queue, neighbor pipeline
// depends on kdb_pkg; driven by kdb_ctrl through kdb_cmd_t
module kdb_datapath #(
	parameter int MAX_DIM = kdb_pkg::MAX_DIM_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kdb_pkg::kdb_cmd_t          cmd,
	output kdb_pkg::kdb_sts_t          sts,
	input  logic                       cfg_we,
	input  logic [kdb_pkg::IDX_W-1:0]  cfg_index,
	input  logic [kdb_pkg::CFG_W-1:0]  cfg_data,
	input  logic [kdb_pkg::CRD_W-1:0]  start_row,
	input  logic [kdb_pkg::CRD_W-1:0]  start_col,
	input  logic [kdb_pkg::CRD_W-1:0]  target_row,
	input  logic [kdb_pkg::CRD_W-1:0]  target_col,
	output logic                       reached,
	output logic [kdb_pkg::MOV_W-1:0]  moves
);
	import kdb_pkg::*;

	localparam int CW    = $clog2(MAX_DIM);
	localparam int AW    = 2 * CW;
	localparam int DEPTH = 1 << AW;
	localparam int CMPW  = (CW + 3 > 10) ? CW + 3 : 10;
	localparam int QW    = AW + MOV_W;
	localparam int KW    = $clog2(STEP_COUNT + 1);

	logic [CFG_W-1:0] rows_q, cols_q;
	logic [AW-1:0]    s_addr_q, t_addr_q, clr_addr_q, addr_s1;
	logic [AW:0]      head_q, tail_q;
	logic [KW-1:0]    k_q;
	logic             ok_s1, found_q, vis_rd;
	logic [MOV_W-1:0] moves_q;
	logic [QW-1:0]    q_rd;

	logic             visited [DEPTH];
	logic [QW-1:0]    queue   [DEPTH];

	logic signed [CMPW-1:0] sr, sc, tr, tc, nr, nc;
	logic [AW-1:0]    cur_addr, nb_addr;
	logic [MOV_W-1:0] cur_dist, next_d;
	logic             nb_ok, ins;

	function automatic logic on_brd(input logic signed [CMPW-1:0] r, input logic signed [CMPW-1:0] c,
			input logic [CFG_W-1:0] nrows, input logic [CFG_W-1:0] ncols);
		return !r[CMPW-1] && !c[CMPW-1]
			&& r < $signed(CMPW'(nrows)) && c < $signed(CMPW'(ncols))
			&& r < $signed(CMPW'(MAX_DIM)) && c < $signed(CMPW'(MAX_DIM));
	endfunction

	assign sr = $signed(CMPW'(start_row));
	assign sc = $signed(CMPW'(start_col));
	assign tr = $signed(CMPW'(target_row));
	assign tc = $signed(CMPW'(target_col));

	assign cur_addr = q_rd[QW-1 -: AW];
	assign cur_dist = q_rd[MOV_W-1:0];
	assign next_d   = (&cur_dist) ? cur_dist : cur_dist + MOV_W'(1);

	assign nr = CMPW'(cur_addr[AW-1:CW]) + CMPW'(step_dr(k_q[2:0]));
	assign nc = CMPW'(cur_addr[CW-1:0]) + CMPW'(step_dc(k_q[2:0]));
	assign nb_addr = {nr[CW-1:0], nc[CW-1:0]};
	assign nb_ok   = on_brd(nr, nc, rows_q, cols_q) && (k_q < KW'(STEP_COUNT));
	assign ins     = cmd.nb && ok_s1 && !vis_rd;

	assign sts.bad      = !(on_brd(sr, sc, rows_q, cols_q) && on_brd(tr, tc, rows_q, cols_q));
	assign sts.same     = (start_row == target_row) && (start_col == target_col);
	assign sts.clr_last = &clr_addr_q;
	assign sts.q_empty  = head_q == tail_q;
	assign sts.nb_last  = k_q == KW'(STEP_COUNT);
	assign sts.found    = found_q;

	assign reached = found_q;
	assign moves   = moves_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q     <= DIM_RST;
			cols_q     <= DIM_RST;
			head_q     <= '0;
			tail_q     <= '0;
			k_q        <= '0;
			ok_s1      <= 1'b0;
			found_q    <= 1'b0;
			moves_q    <= '0;
			clr_addr_q <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_ROWS) rows_q <= cfg_data;
			if (cfg_we && cfg_index == REG_COLS) cols_q <= cfg_data;
			if (cmd.load) begin
				found_q    <= sts.same && !sts.bad;
				moves_q    <= '0;
				clr_addr_q <= '0;
			end
			if (cmd.clr) clr_addr_q <= clr_addr_q + AW'(1);
			if (cmd.init) begin
				head_q <= '0;
				tail_q <= (AW + 1)'(1);
			end
			if (cmd.pop) begin
				head_q <= head_q + (AW + 1)'(1);
				k_q    <= '0;
				ok_s1  <= 1'b0;
			end
			if (cmd.nb) begin
				ok_s1 <= nb_ok;
				if (!sts.nb_last) k_q <= k_q + KW'(1);
			end
			if (ins) begin
				tail_q <= tail_q + (AW + 1)'(1);
				if (addr_s1 == t_addr_q) begin
					found_q <= 1'b1;
					moves_q <= next_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			s_addr_q <= {sr[CW-1:0], sc[CW-1:0]};
			t_addr_q <= {tr[CW-1:0], tc[CW-1:0]};
		end
		if (cmd.nb) addr_s1 <= nb_addr;
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) visited[clr_addr_q] <= 1'b0;
		else if (cmd.init) visited[s_addr_q] <= 1'b1;
		else if (ins) visited[addr_s1] <= 1'b1;
		vis_rd <= visited[nb_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.init) queue[AW'(0)] <= {s_addr_q, MOV_W'(0)};
		else if (ins) queue[tail_q[AW-1:0]] <= {addr_s1, next_d};
		if (cmd.pop) q_rd <= queue[head_q[AW-1:0]];
	end

endmodule

@@ sv/kdb_ctrl.sv @@
// controller state machine: sequences clear, search and result delivery
// depends on kdb_pkg; commands kdb_datapath
module kdb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  kdb_pkg::kdb_sts_t sts,
	output kdb_pkg::kdb_cmd_t cmd
);
	import kdb_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CLEAR = 7'b0000010,
		S_INIT  = 7'b0000100,
		S_POP   = 7'b0001000,
		S_QWAIT = 7'b0010000,
		S_NB    = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = state_q == S_OUT;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (sts.bad || sts.same) ? S_OUT : S_CLEAR;
				end
			end
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) state_d = S_INIT;
			end
			S_INIT: begin
				cmd.init = 1'b1;
				state_d  = S_POP;
			end
			S_POP: begin
				if (sts.found || sts.q_empty) state_d = S_OUT;
				else begin
					cmd.pop = 1'b1;
					state_d = S_QWAIT;
				end
			end
			S_QWAIT: state_d = S_NB;
			S_NB: begin
				cmd.nb = 1'b1;
				if (sts.nb_last) state_d = S_POP;
			end
			S_OUT: begin
				if (!out_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

@@ sv/knight_distance_bfs.sv @@
// knight_distance_bfs: least knight moves between two squares of a board
// top level; depends on kdb_pkg, kdb_ctrl, kdb_datapath
//
// one request on the input channel carries start and target squares; it is
// taken when in_valid is high and in_stall low. in_stall stays high from the
// accepted request until its single result has been taken.
// the result (reached, moves) is held with out_valid until out_stall is low.
// board_rows / board_cols are written through cfg_valid/cfg_ready (always
// ready), index 0 rows, 1 cols. the user must write them only while no
// request is in flight; the block itself does not enforce this.
// a request with either square off the board, or start equal to target,
// answers in the next cycle. otherwise a sweep first clears every address
// of the visited memory; then each square popped from the frontier queue
// takes one queue read, then eight neighbor checks pipelined on the visited
// memory read port. the search ends at the next pop after the target is
// marked, or when the queue is empty.
// reset clears the control state and sets both board registers to 8; the
// memories need no reset since every request clears what it reads.
module knight_distance_bfs #(
	parameter int MAX_DIM = kdb_pkg::MAX_DIM_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [kdb_pkg::CRD_W-1:0]  start_row,
	input  logic [kdb_pkg::CRD_W-1:0]  start_col,
	input  logic [kdb_pkg::CRD_W-1:0]  target_row,
	input  logic [kdb_pkg::CRD_W-1:0]  target_col,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       reached,
	output logic [kdb_pkg::MOV_W-1:0]  moves,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [kdb_pkg::IDX_W-1:0]  cfg_index,
	input  logic [kdb_pkg::CFG_W-1:0]  cfg_data
);
	import kdb_pkg::*;

	kdb_cmd_t cmd;
	kdb_sts_t sts;

	assign cfg_ready = 1'b1;

	kdb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	kdb_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.start_row  (start_row),
		.start_col  (start_col),
		.target_row (target_row),
		.target_col (target_col),
		.reached    (reached),
		.moves      (moves)
	);

endmodule

@@ sv/kdb_checker.sv @@
// port-level checks on knight_distance_bfs, attached by bind
// depends on kdb_pkg
module kdb_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic                      reached,
	input logic [kdb_pkg::MOV_W-1:0] moves
);
	import kdb_pkg::*;

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// unreachable answers carry no count
	a_zero_moves: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reached |-> moves == '0)
		else $error("moves nonzero on unreached result");

	// busy right after a request is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken before result");

	// no new request while a result waits
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

endmodule

bind knight_distance_bfs kdb_checker u_kdb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.reached   (reached),
	.moves     (moves)
);
